// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. The enclosing module must have clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define VXY_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define VXY_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/vxy_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vxy_pkg;

    localparam int DAC_BITS    = 10;
    localparam int COORD_W     = 12;
    localparam int STEPS_W     = 7;
    localparam int WORD_W      = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [WORD_W-1:0]  CMD_CHAN_A       = 16'h3000;
    localparam logic [WORD_W-1:0]  CMD_CHAN_B       = 16'hB000;
    localparam logic [STEPS_W-1:0] DRAW_STEPS_RESET = 7'd18;
    localparam logic [STEPS_W-1:0] MOVE_STEPS_RESET = 7'd1;

    typedef logic [DAC_BITS-1:0] coord_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DRAW_STEPS = 1'b0,
        REG_MOVE_STEPS = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_X,
        ST_DIV_X,
        ST_START_Y,
        ST_DIV_Y,
        ST_EMIT
    } state_t;

    // Negative values go to zero and values above full scale go to full scale.
    function automatic coord_t clamp_coord(input logic signed [COORD_W-1:0] v);
        coord_t r;
        if (v[COORD_W-1])
        begin
            r = '0;
        end
        else if (v[COORD_W-2:DAC_BITS] != '0)
        begin
            r = '1;
        end
        else
        begin
            r = v[DAC_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] dac_word(input logic [WORD_W-1:0] cmd,
                                                   input coord_t v);
        return cmd | WORD_W'({v, 2'b00});
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vxy_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface vxy_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [vxy_pkg::COORD_W-1:0]      target_x;
    logic signed [vxy_pkg::COORD_W-1:0]      target_y;
    logic                                    pen_down;
    logic                                    forget_position;

    modport source (output valid, target_x, target_y, pen_down, forget_position,
                    input ready);
    modport sink (input valid, target_x, target_y, pen_down, forget_position,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vxy_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface vxy_out_if;
    logic                          valid;
    logic                          ready;
    logic [vxy_pkg::DAC_BITS-1:0]  dac_x;
    logic [vxy_pkg::DAC_BITS-1:0]  dac_y;
    logic [vxy_pkg::WORD_W-1:0]    word_a;
    logic [vxy_pkg::WORD_W-1:0]    word_b;
    logic                          last;

    modport source (output valid, dac_x, dac_y, word_a, word_b, last, input ready);
    modport sink (input valid, dac_x, dac_y, word_a, word_b, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vxy_div_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The divisor must be nonzero.
module vxy_div_unit #(
    parameter int DVD_W = 10,
    parameter int DVS_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output logic      [DVS_W-1:0] remainder,
    output logic                  done
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    // The dividend shifts out of the top of quo_reg as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/vector_xy_line_interpolator.sv -----
// Sequence: after an item transfers, the serial divider runs for X and then for Y, then points leave.
// Items are taken only in ST_IDLE; points follow one per cycle while point.ready allows.
// The shared serial divider, run once per axis, sets the setup time of each item.
// Reset (rst_n, async, active low): position (0,0) unknown, draw_steps 18, move_steps 1.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vector_xy_line_interpolator #(
    parameter int MAX_STEPS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [vxy_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [vxy_pkg::STEPS_W-1:0]         cfg_data,
    vxy_in_if.sink                                   target,
    vxy_out_if.source                                point
);

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int DB     = vxy_pkg::DAC_BITS;

    vxy_pkg::state_t state_reg, state_next;

    logic [vxy_pkg::STEPS_W-1:0] draw_steps_reg, move_steps_reg;
    logic [DB-1:0]     pos_x_reg, pos_y_reg;
    logic              known_reg;
    logic [DB-1:0]     start_x_reg, start_y_reg;
    logic [DB-1:0]     mag_x_reg, mag_y_reg;
    logic              neg_x_reg, neg_y_reg;
    logic [STEP_W-1:0] n_reg, k_reg;
    logic [DB-1:0]     q0x_reg, q0y_reg, qx_reg, qy_reg;
    logic [STEP_W-1:0] r0x_reg, r0y_reg, rx_reg, ry_reg;
    logic              out_valid_reg;
    logic [DB-1:0]     dac_x_reg, dac_y_reg;
    logic              last_reg;

    logic              in_xfer;
    logic              div_start, div_done, cap_x, cap_y, emit_go;
    logic [DB-1:0]     div_dividend;
    logic [DB-1:0]     div_quo;
    logic [STEP_W-1:0] div_rem;

    // Input side.
    logic [DB-1:0]     tx, ty;
    logic signed [DB:0] dx, dy;
    logic [DB:0]       dx_abs, dy_abs;
    logic              known_eff;
    logic [vxy_pkg::STEPS_W-1:0] steps_raw;
    logic [STEP_W-1:0] steps_lim, n_in;

    assign in_xfer   = target.valid & target.ready;
    assign tx        = vxy_pkg::clamp_coord(target.target_x);
    assign ty        = vxy_pkg::clamp_coord(target.target_y);
    assign dx        = $signed({1'b0, tx}) - $signed({1'b0, pos_x_reg});
    assign dy        = $signed({1'b0, ty}) - $signed({1'b0, pos_y_reg});
    assign dx_abs    = dx[DB] ? (DB + 1)'(-dx) : dx;
    assign dy_abs    = dy[DB] ? (DB + 1)'(-dy) : dy;
    assign known_eff = known_reg & ~target.forget_position;
    assign steps_raw = target.pen_down ? draw_steps_reg : move_steps_reg;

    always_comb
    begin
        priority if (steps_raw == '0)
        begin
            steps_lim = STEP_W'(1);
        end
        else if (32'(steps_raw) > 32'(MAX_STEPS))
        begin
            steps_lim = STEP_W'(MAX_STEPS);
        end
        else
        begin
            steps_lim = STEP_W'(steps_raw);
        end
    end

    // A single step from the old position lands on the target, which covers a
    // move whose start is unknown.
    assign n_in = (!target.pen_down && !known_eff) ? STEP_W'(1) : steps_lim;

    // Per-point accumulation of |d|*k/n as quotient and remainder.
    logic [STEP_W:0]   rsx, rsy, rsx_sub, rsy_sub;
    logic              wrap_x, wrap_y;
    logic [STEP_W-1:0] rx_new, ry_new, k_new;
    logic [DB-1:0]     qx_new, qy_new, px, py;
    logic              k_last;

    assign rsx     = {1'b0, rx_reg} + {1'b0, r0x_reg};
    assign rsy     = {1'b0, ry_reg} + {1'b0, r0y_reg};
    assign wrap_x  = rsx >= {1'b0, n_reg};
    assign wrap_y  = rsy >= {1'b0, n_reg};
    assign rsx_sub = rsx - {1'b0, n_reg};
    assign rsy_sub = rsy - {1'b0, n_reg};
    assign rx_new  = wrap_x ? rsx_sub[STEP_W-1:0] : rsx[STEP_W-1:0];
    assign ry_new  = wrap_y ? rsy_sub[STEP_W-1:0] : rsy[STEP_W-1:0];
    assign qx_new  = qx_reg + q0x_reg + DB'(wrap_x);
    assign qy_new  = qy_reg + q0y_reg + DB'(wrap_y);
    assign px      = neg_x_reg ? start_x_reg - qx_new : start_x_reg + qx_new;
    assign py      = neg_y_reg ? start_y_reg - qy_new : start_y_reg + qy_new;
    assign k_new   = k_reg + STEP_W'(1);
    assign k_last  = k_new == n_reg;

    vxy_div_unit #(
        .DVD_W (DB),
        .DVS_W (STEP_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (n_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Sequencer outputs.
    always_comb
    begin
        target.ready = state_reg == vxy_pkg::ST_IDLE;
        div_start    = (state_reg == vxy_pkg::ST_START_X) ||
                       (state_reg == vxy_pkg::ST_START_Y);
        div_dividend = (state_reg == vxy_pkg::ST_START_X) ? mag_x_reg : mag_y_reg;
        cap_x        = (state_reg == vxy_pkg::ST_DIV_X) && div_done;
        cap_y        = (state_reg == vxy_pkg::ST_DIV_Y) && div_done;
        emit_go      = (state_reg == vxy_pkg::ST_EMIT) && (!out_valid_reg || point.ready);
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vxy_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = vxy_pkg::ST_START_X;
                end
            end
            vxy_pkg::ST_START_X: state_next = vxy_pkg::ST_DIV_X;
            vxy_pkg::ST_DIV_X:
            begin
                if (div_done)
                begin
                    state_next = vxy_pkg::ST_START_Y;
                end
            end
            vxy_pkg::ST_START_Y: state_next = vxy_pkg::ST_DIV_Y;
            vxy_pkg::ST_DIV_Y:
            begin
                if (div_done)
                begin
                    state_next = vxy_pkg::ST_EMIT;
                end
            end
            vxy_pkg::ST_EMIT:
            begin
                if (emit_go && k_last)
                begin
                    state_next = vxy_pkg::ST_IDLE;
                end
            end
            default: state_next = vxy_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vxy_pkg::ST_IDLE;
            draw_steps_reg <= vxy_pkg::DRAW_STEPS_RESET;
            move_steps_reg <= vxy_pkg::MOVE_STEPS_RESET;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            known_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (vxy_pkg::cfg_reg_t'(cfg_index))
                    vxy_pkg::REG_DRAW_STEPS: draw_steps_reg <= cfg_data;
                    vxy_pkg::REG_MOVE_STEPS: move_steps_reg <= cfg_data;
                endcase
            end
            if (in_xfer)
            begin
                pos_x_reg <= tx;
                pos_y_reg <= ty;
                known_reg <= 1'b1;
            end
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (point.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            start_x_reg <= pos_x_reg;
            start_y_reg <= pos_y_reg;
            mag_x_reg   <= dx_abs[DB-1:0];
            mag_y_reg   <= dy_abs[DB-1:0];
            neg_x_reg   <= dx[DB];
            neg_y_reg   <= dy[DB];
            n_reg       <= n_in;
            k_reg       <= '0;
            qx_reg      <= '0;
            qy_reg      <= '0;
            rx_reg      <= '0;
            ry_reg      <= '0;
        end
        if (cap_x)
        begin
            q0x_reg <= div_quo;
            r0x_reg <= div_rem;
        end
        if (cap_y)
        begin
            q0y_reg <= div_quo;
            r0y_reg <= div_rem;
        end
        if (emit_go)
        begin
            k_reg     <= k_new;
            qx_reg    <= qx_new;
            qy_reg    <= qy_new;
            rx_reg    <= rx_new;
            ry_reg    <= ry_new;
            dac_x_reg <= px;
            dac_y_reg <= py;
            last_reg  <= k_last;
        end
    end

    assign point.valid  = out_valid_reg;
    assign point.dac_x  = dac_x_reg;
    assign point.dac_y  = dac_y_reg;
    assign point.word_a = vxy_pkg::dac_word(vxy_pkg::CMD_CHAN_A, dac_x_reg);
    assign point.word_b = vxy_pkg::dac_word(vxy_pkg::CMD_CHAN_B, dac_y_reg);
    assign point.last   = last_reg;

    `VXY_ASSERT(a_step_below_count, (state_reg == vxy_pkg::ST_EMIT) |-> (k_reg < n_reg), "step index reached the step count while emitting")
    `VXY_ASSERT(a_rem_below_count, (state_reg == vxy_pkg::ST_EMIT) |-> (rx_reg < n_reg && ry_reg < n_reg), "running remainder not below the step count")
    `VXY_ASSERT(a_last_ends_item, (emit_go && k_last) |=> (state_reg == vxy_pkg::ST_IDLE && point.valid && point.last), "final point did not end the item")
    `VXY_ASSERT_NEVER(a_done_in_div, div_done && state_reg != vxy_pkg::ST_DIV_X && state_reg != vxy_pkg::ST_DIV_Y, "divider finished outside a divide state")

endmodule

`default_nettype wire
